// File: hw/rtl/mftt_pkg.sv
package mftt_pkg;

  localparam int unsigned CountsPerTurnDef = 8192;
  localparam int unsigned SlotsPerBusDef   = 7;

  localparam int unsigned IdW     = 11;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned AngW    = 16;
  localparam int unsigned TurnW   = 16;
  localparam int unsigned TotalW  = 30;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [IdW-1:0]  BaseIdReset  = 11'd513;
  localparam logic [ThrW-1:0] WrapThrReset = 16'd6500;

  localparam logic CfgBaseId  = 1'b0;
  localparam logic CfgWrapThr = 1'b1;

  localparam logic signed [TurnW-1:0] TurnMax = 16'sh7fff;
  localparam logic signed [TurnW-1:0] TurnMin = 16'sh8000;

  typedef struct packed {
    logic                    hit;
    logic                    bus;
    logic [SlotW-1:0]        slot;
    logic [AngW-1:0]         angle;
    logic signed [15:0]      speed;
    logic signed [15:0]      current;
    logic [7:0]              temperature;
  } frame_t;

endpackage

// File: hw/rtl/mftt_frame_decode.sv
module mftt_frame_decode (
  input  logic                        bus_i,
  input  logic [mftt_pkg::IdW-1:0]    ident_i,
  input  logic [63:0]                 payload_i,
  input  logic [mftt_pkg::IdW-1:0]    base_id_i,
  output mftt_pkg::frame_t            frame_o
);

  logic [mftt_pkg::IdW-1:0] offs;
  logic                     above;
  logic                     ok;

  assign offs  = ident_i - base_id_i;
  assign above = ident_i >= base_id_i;

  always_comb begin
    if (!bus_i) begin
      ok = offs <= 11'd4;
    end else begin
      ok = (offs == 11'd0) || (offs == 11'd3) || (offs == 11'd5) || (offs == 11'd6);
    end
  end

  always_comb begin
    frame_o.hit         = above && ok;
    frame_o.bus         = bus_i;
    frame_o.slot        = offs[mftt_pkg::SlotW-1:0];
    frame_o.angle       = payload_i[63:48];
    frame_o.speed       = $signed(payload_i[47:32]);
    frame_o.current     = $signed(payload_i[31:16]);
    frame_o.temperature = payload_i[15:8];
  end

endmodule

// File: hw/rtl/mftt_turn_track.sv
module mftt_turn_track #(
  parameter int unsigned COUNTS_PER_TURN = mftt_pkg::CountsPerTurnDef,
  parameter int unsigned SLOTS_PER_BUS   = mftt_pkg::SlotsPerBusDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   upd_i,
  input  mftt_pkg::frame_t                       frame_i,
  input  logic [mftt_pkg::ThrW-1:0]              wrap_thr_i,
  output logic signed [mftt_pkg::TurnW-1:0]      turns_o,
  output logic [mftt_pkg::TotalW-1:0]            total_o
);

  localparam int unsigned NumRec = 2 * SLOTS_PER_BUS;
  localparam int unsigned IdxW   = $clog2(NumRec);
  localparam logic [mftt_pkg::TotalW-1:0] Cpt = mftt_pkg::TotalW'(COUNTS_PER_TURN);

  logic [mftt_pkg::AngW-1:0]           prev_q [NumRec];
  logic signed [mftt_pkg::TurnW-1:0]   turn_q [NumRec];
  logic [mftt_pkg::TotalW-1:0]         offs_q [NumRec];
  logic [NumRec-1:0]                   seen_q;

  logic [IdxW-1:0]                     idx;
  logic signed [mftt_pkg::AngW:0]      diff;
  logic signed [mftt_pkg::AngW+1:0]    diff_x;
  logic signed [mftt_pkg::AngW+1:0]    thr_x;
  logic                                inc;
  logic                                dec;
  logic signed [mftt_pkg::TurnW-1:0]   turn_d;
  logic [mftt_pkg::TotalW-1:0]         offs_d;

  assign idx = frame_i.bus ? IdxW'(SLOTS_PER_BUS) + IdxW'(frame_i.slot)
                           : IdxW'(frame_i.slot);

  assign diff   = $signed({1'b0, frame_i.angle}) - $signed({1'b0, prev_q[idx]});
  assign diff_x = {diff[mftt_pkg::AngW], diff};
  assign thr_x  = $signed({2'b00, wrap_thr_i});

  assign inc = seen_q[idx] && (diff_x < -thr_x) && (turn_q[idx] != mftt_pkg::TurnMax);
  assign dec = seen_q[idx] && (diff_x > thr_x) && (turn_q[idx] != mftt_pkg::TurnMin);

  always_comb begin
    turn_d = turn_q[idx];
    offs_d = offs_q[idx];
    if (inc) begin
      turn_d = turn_q[idx] + 16'sd1;
      offs_d = offs_q[idx] + Cpt;
    end else if (dec) begin
      turn_d = turn_q[idx] - 16'sd1;
      offs_d = offs_q[idx] - Cpt;
    end
  end

  assign turns_o = turn_d;
  assign total_o = offs_d + mftt_pkg::TotalW'(frame_i.angle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int k = 0; k < NumRec; k++) begin
        prev_q[k] <= '0;
        turn_q[k] <= '0;
        offs_q[k] <= '0;
      end
    end else if (upd_i) begin
      seen_q[idx] <= 1'b1;
      prev_q[idx] <= frame_i.angle;
      turn_q[idx] <= turn_d;
      offs_q[idx] <= offs_d;
    end
  end

endmodule

// File: hw/rtl/motor_feedback_turn_tracker_unit.sv
// motor feedback turn tracker
// slave stream: one received feedback frame per beat, tuser is the bus,
// tdata holds the identifier and the eight payload bytes
// master stream: one record per accepted frame, tuser is the source bus,
// tdata holds slot, angle, speed, current, temperature, turn count and
// multi-turn angle
// frames whose slot is not served on their bus are dropped with no beat out
// each input beat goes through the input register, then the result register;
// throughput is one frame per cycle unless the receiver stalls, set by the
// single read-modify-write of the slot record between the two registers
// the receiver stalling holds the result register; the input register still
// takes one more beat, and dropped frames keep flowing while stalled
// cfg_we_i writes register cfg_idx_i (0 base identifier, 1 wrap threshold)
// from cfg_data_i; user must write only while the block is idle (unenforced)
// reset clears all slot records (angle, turns, offset, first-frame flag) and
// both stream valid bits and loads the default base identifier and threshold
module motor_feedback_turn_tracker_unit #(
  parameter int unsigned COUNTS_PER_TURN = mftt_pkg::CountsPerTurnDef,
  parameter int unsigned SLOTS_PER_BUS   = mftt_pkg::SlotsPerBusDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [mftt_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [79:0]               s_axis_tdata,   // frame_identifier, payload
  input  logic                      s_axis_tuser,   // bus_select
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // motor_slot, angle, speed, current, temperature, turn_count, total_angle
  output logic [111:0]              m_axis_tdata,
  output logic                      m_axis_tuser    // source_bus
);

  logic [mftt_pkg::IdW-1:0]   base_id_q;
  logic [mftt_pkg::ThrW-1:0]  wrap_thr_q;

  logic                       in_valid_q;
  logic                       in_bus_q;
  logic [mftt_pkg::IdW-1:0]   in_ident_q;
  logic [63:0]                in_payload_q;

  logic                       out_valid_q;
  logic [104:0]               out_data_q;
  logic                       out_bus_q;

  mftt_pkg::frame_t                   frame;
  logic signed [mftt_pkg::TurnW-1:0]  turns;
  logic [mftt_pkg::TotalW-1:0]        total;
  logic                               out_free;
  logic                               upd;
  logic                               adv;
  logic                               in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q  <= mftt_pkg::BaseIdReset;
      wrap_thr_q <= mftt_pkg::WrapThrReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mftt_pkg::CfgBaseId:  base_id_q  <= cfg_data_i[mftt_pkg::IdW-1:0];
        mftt_pkg::CfgWrapThr: wrap_thr_q <= cfg_data_i[mftt_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  mftt_frame_decode u_decode (
    .bus_i     (in_bus_q),
    .ident_i   (in_ident_q),
    .payload_i (in_payload_q),
    .base_id_i (base_id_q),
    .frame_o   (frame)
  );

  mftt_turn_track #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN),
    .SLOTS_PER_BUS   (SLOTS_PER_BUS)
  ) u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .frame_i    (frame),
    .wrap_thr_i (wrap_thr_q),
    .turns_o    (turns),
    .total_o    (total)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign upd           = in_valid_q && frame.hit && out_free;
  assign adv           = in_valid_q && (!frame.hit || out_free);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_bus_q     <= s_axis_tuser;
      in_ident_q   <= s_axis_tdata[10:0];
      in_payload_q <= s_axis_tdata[74:11];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      out_bus_q  <= frame.bus;
      out_data_q <= {total, turns, frame.temperature, frame.current, frame.speed,
                     frame.angle, frame.slot};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_bus_q;
  assign m_axis_tdata  = {7'd0, out_data_q};

endmodule
